// ===== hdl/jitter_buffer_clock_correction_macros.svh =====
// Assertion macros used by the checker file of the clock correction block.
`ifndef JITTER_BUFFER_CLOCK_CORRECTION_MACROS_SVH
`define JITTER_BUFFER_CLOCK_CORRECTION_MACROS_SVH

// Checked only while the block is out of reset.
`define JBCC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define JBCC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/jbcc_pkg.sv =====
// Types and constants of the jitter buffer clock correction block.
package jbcc_pkg;

    // Serial divider sizes: dividend, divisor and iteration counter.
    localparam int DIV_W = 30;
    localparam int DSR_W = 21;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 136;

    localparam logic [19:0]      SAFETY_RST  = 20'd10000;
    localparam logic [29:0]      TICK_NS_RST = 30'd16666667;
    localparam logic [DSR_W-1:0] NS_PER_US   = 21'd1000;

    // Configuration register indexes.
    localparam logic CFG_SAFETY = 1'b0;
    localparam logic CFG_TICK   = 1'b1;

    typedef struct packed {
        logic [2:0]         pad;
        logic [19:0]        jitter_us;
        logic signed [40:0] latest_server_tick;
        logic [39:0]        sim_tick;
    } t_in_data;

    typedef struct packed {
        logic               pad;
        logic [20:0]        target_behind;
        logic signed [41:0] clock_offset;
        logic signed [41:0] clock_error;
        logic signed [29:0] correction_ns;
    } t_out_data;

endpackage

// ===== hdl/jitter_buffer_clock_correction.sv =====
// Top level of the jitter buffer clock correction block.
//
// One input word per simulation tick on the s_axis channel carries the local
// tick, the newest server tick, the measured jitter and (in tuser) the flag
// that some subscription is active. For each input word exactly one result
// word leaves on the m_axis channel: correction, clock error, clock offset,
// target lag and (in tuser) the request to forget the latest server tick.
// When no server tick is known or nothing is active, the word goes from
// ST_IDLE straight to ST_OUT. Otherwise it takes two passes through the one
// bit-serial divider (tick length in us, then the lag in ticks), then the
// lag update, the error and the scaled correction, each in its own state.
// One word is worked on at a time; a new word is taken once the previous
// one has reached the output register, even while that result is still
// waiting for the receiver. If the receiver stalls, the finished word stays
// in the block until the output register frees up.
// Reset clears the lag to zero and loads the default safety margin and tick
// length. Configuration writes are taken at any edge with i_cfg_we high.
module jitter_buffer_clock_correction (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [29:0]                     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sim_tick[39:0], latest_server_tick[80:40], jitter_us[100:81], zero pad
    input  logic [jbcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // any_active[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // correction_ns[29:0], clock_error[71:30], clock_offset[113:72],
    // target_behind[134:114], zero pad
    output logic [jbcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // reset_latest[0]
    output logic                            m_axis_tuser
);
    import jbcc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_START2,
        ST_DIV2,
        ST_LAG,
        ST_ERR,
        ST_CORR,
        ST_OUT
    } t_state;

    t_state r_state;

    logic [19:0]        r_safety;
    logic [29:0]        r_tick_ns;
    logic [20:0]        r_lag;
    logic [39:0]        r_sim;
    logic signed [40:0] r_latest;
    logic [19:0]        r_jitter;
    logic [20:0]        r_tick_us;
    logic [21:0]        r_comp;
    logic [41:0]        r_off;
    logic [41:0]        r_err;
    logic [29:0]        r_corr;
    logic               r_rst_flag;
    logic               r_m_valid;
    t_out_data          r_m_data;
    logic               r_m_user;

    t_in_data   in_word;
    logic       accept;
    logic       bypass;
    logic       div_start;
    logic       div_done;
    logic [DIV_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quotient;
    logic [21:0] num;
    logic [21:0] lag_ext;
    logic [21:0] lag_diff;
    logic        err_neg;
    logic        err_pos;
    logic        err_big;
    logic [2:0]  steps_mag;
    logic [32:0] prod;
    logic [29:0] mag;
    logic        out_free;

    assign in_word       = t_in_data'(s_axis_tdata);
    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign bypass        = in_word.latest_server_tick[40] || !s_axis_tuser;
    assign out_free      = !r_m_valid || m_axis_tready;

    // The divider first turns the tick length into microseconds, then
    // computes the rounded-up lag from jitter plus safety margin.
    assign num = {2'b00, r_jitter} + {2'b00, r_safety} + {1'b0, r_tick_us} - 22'd1;
    assign div_start    = (accept && !bypass) || (r_state == ST_START2);
    assign div_dividend = (r_state == ST_IDLE) ? r_tick_ns : {8'd0, num};
    assign div_divisor  = (r_state == ST_IDLE) ? NS_PER_US : r_tick_us;

    jbcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign lag_ext  = {1'b0, r_lag};
    assign lag_diff = (r_comp > lag_ext) ? (r_comp - lag_ext) : (lag_ext - r_comp);

    // The error is clamped to four ticks; a full clamp divides by 8, else by 64.
    assign err_neg = r_err[41];
    assign err_pos = !r_err[41] && (r_err != '0);
    assign err_big = err_neg ? ($signed(r_err) <= -42'sd4) : ($signed(r_err) >= 42'sd4);
    assign steps_mag = err_big ? 3'd4 : (err_neg ? (~r_err[2:0] + 3'd1) : r_err[2:0]);
    assign prod = steps_mag[2] ? {1'b0, r_tick_ns, 2'b00}
                : ((steps_mag[1] ? {2'b00, r_tick_ns, 1'b0} : 33'd0)
                 + (steps_mag[0] ? {3'b000, r_tick_ns} : 33'd0));
    assign mag = err_big ? prod[32:3] : {3'b000, prod[32:6]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_safety  <= SAFETY_RST;
            r_tick_ns <= TICK_NS_RST;
            r_lag     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAFETY: r_safety  <= i_cfg_data[19:0];
                    CFG_TICK:   r_tick_ns <= i_cfg_data;
                    default:    r_safety  <= r_safety;
                endcase
            end

            // In ST_OUT a word that leaves is replaced by the next one below.
            if (r_m_valid && m_axis_tready && r_state != ST_OUT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_sim      <= in_word.sim_tick;
                        r_latest   <= in_word.latest_server_tick;
                        r_jitter   <= in_word.jitter_us;
                        r_off      <= '0;
                        r_err      <= '0;
                        r_corr     <= '0;
                        r_rst_flag <= !in_word.latest_server_tick[40] && !s_axis_tuser;
                        r_state    <= bypass ? ST_OUT : ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_tick_us <= (div_quotient == '0) ? 21'd1 : div_quotient[20:0];
                        r_state   <= ST_START2;
                    end
                end
                ST_START2: begin
                    r_state <= ST_DIV2;
                end
                ST_DIV2: begin
                    if (div_done) begin
                        r_comp  <= div_quotient[21:0];
                        r_state <= ST_LAG;
                    end
                end
                ST_LAG: begin
                    if (r_lag == '0 || lag_diff >= 22'd2) begin
                        r_lag <= r_comp[20:0];
                    end
                    r_off   <= {2'b00, r_sim} - {r_latest[40], r_latest};
                    r_state <= ST_ERR;
                end
                ST_ERR: begin
                    r_err   <= r_off + {21'd0, r_lag};
                    r_state <= ST_CORR;
                end
                ST_CORR: begin
                    r_corr  <= err_pos ? (30'd0 - mag) : mag;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_valid              <= 1'b1;
                        r_m_data.pad           <= 1'b0;
                        r_m_data.target_behind <= r_lag;
                        r_m_data.clock_offset  <= r_off;
                        r_m_data.clock_error   <= r_err;
                        r_m_data.correction_ns <= r_corr;
                        r_m_user               <= r_rst_flag;
                        r_state                <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_m_data);
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== hdl/jbcc_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
module jbcc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [jbcc_pkg::DIV_W-1:0] i_dividend,
    input  logic [jbcc_pkg::DSR_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [jbcc_pkg::DIV_W-1:0] o_quotient
);
    import jbcc_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DIV_W-1:0] r_quo;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] trial;
    logic             fits;

    // Bring the next dividend bit into the partial remainder and try the subtract.
    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dsr};
    assign fits    = !trial[DSR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/jbcc_chk.sv =====
// Port-level checker of the jitter buffer clock correction block and its bind.
`include "jitter_buffer_clock_correction_macros.svh"

module jbcc_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [jbcc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    logic        stalled;
    logic        rst_req;
    logic        zero_result;
    logic [41:0] out_err;
    logic [41:0] out_off;
    logic [20:0] out_lag;
    logic        lag_gap_ok;

    assign stalled     = m_axis_tvalid && !m_axis_tready;
    assign rst_req     = m_axis_tvalid && m_axis_tuser;
    assign zero_result = (m_axis_tdata[113:0] == 114'd0);
    assign out_err     = m_axis_tdata[71:30];
    assign out_off     = m_axis_tdata[113:72];
    assign out_lag     = m_axis_tdata[134:114];
    assign lag_gap_ok  = (out_err == out_off) || ((out_err - out_off) == {21'd0, out_lag});

    // A word waiting for the receiver is not withdrawn.
    `JBCC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (stalled |=> m_axis_tvalid), "stalled word dropped")

    // Reset leaves no result on the output.
    `JBCC_ASSERT(a_rst_empty, i_clk, (!i_rst_n |=> !m_axis_tvalid), "output valid after reset")

    // A reset request comes with zero correction, error and offset.
    `JBCC_ASSERT_RST(a_rst_req_zero, i_clk, i_rst_n, (rst_req |-> zero_result), "reset with data")

    // Where error and offset differ, they differ by exactly the target lag.
    `JBCC_ASSERT_RST(a_err_lag, i_clk, i_rst_n, (m_axis_tvalid |-> lag_gap_ok), "lag gap wrong")

endmodule

bind jitter_buffer_clock_correction jbcc_chk u_jbcc_chk (.*);
